// ===== hdl/u2u_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 byte-stream decoder.
// No dependencies; imported by u2u_step, utf8_to_utf16_decoder and the testbench.
package u2u_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned AccW    = 31;
  localparam int unsigned RemW    = 3;
  localparam int unsigned StatusW = 3;

  localparam logic [UnitW-1:0] ReplaceChar = 16'h003F;
  localparam logic [1:0]       ContTag     = 2'b10;

  typedef enum logic [StatusW-1:0] {
    ST_PENDING = 3'd0,
    ST_EMIT    = 3'd1,
    ST_ILLEGAL = 3'd2,
    ST_BADCONT = 3'd3,
    ST_IGNORED = 3'd4,
    ST_TRUNC   = 3'd5
  } status_t;

  // Decoder state carried from one byte to the next
  typedef struct packed {
    logic [RemW-1:0] remaining;
    logic [AccW-1:0] acc;
    logic            halted;
  } dec_state_t;

  // One result item
  typedef struct packed {
    status_t          status;
    logic [UnitW-1:0] code_unit;
    logic             halted_after;
  } dec_result_t;

endpackage

// ===== hdl/u2u_step.sv =====
// Per-byte decode logic: current state plus one byte gives next state and result.
// Depends on u2u_pkg.
module u2u_step
  import u2u_pkg::*;
(
  input  dec_state_t       cur,
  input  logic [ByteW-1:0] byte_value,
  input  logic             last_byte,
  output dec_state_t       nxt,
  output dec_result_t      res
);

  logic [2:0]      lead_cnt;
  logic [6:0]      lead_mask;
  logic [AccW-1:0] cont_acc;
  logic [RemW-1:0] cont_rem;

  // Count leading ones of the byte, saturating at seven
  always_comb begin
    if (!byte_value[7])      lead_cnt = 3'd0;
    else if (!byte_value[6]) lead_cnt = 3'd1;
    else if (!byte_value[5]) lead_cnt = 3'd2;
    else if (!byte_value[4]) lead_cnt = 3'd3;
    else if (!byte_value[3]) lead_cnt = 3'd4;
    else if (!byte_value[2]) lead_cnt = 3'd5;
    else if (!byte_value[1]) lead_cnt = 3'd6;
    else                     lead_cnt = 3'd7;
  end

  // Payload bits of a lead byte
  always_comb begin
    case (lead_cnt)
      3'd2:    lead_mask = 7'h1F;
      3'd3:    lead_mask = 7'h0F;
      3'd4:    lead_mask = 7'h07;
      3'd5:    lead_mask = 7'h03;
      3'd6:    lead_mask = 7'h01;
      default: lead_mask = 7'h00;
    endcase
  end

  assign cont_acc = {cur.acc[AccW-7:0], byte_value[5:0]};
  assign cont_rem = cur.remaining - RemW'(1);

  // Next state and result
  always_comb begin
    logic [AccW-1:0] fin_val;
    logic            fin_en;
    fin_val          = '0;
    fin_en           = 1'b0;
    nxt              = cur;
    res.status       = ST_PENDING;
    res.code_unit    = '0;
    if (cur.halted) begin
      res.status = ST_IGNORED;
    end else if (cur.remaining == '0) begin
      if (lead_cnt == 3'd0) begin
        fin_en  = 1'b1;
        fin_val = AccW'(byte_value);
      end else if (lead_cnt == 3'd1 || lead_cnt == 3'd7) begin
        res.status = ST_ILLEGAL;
      end else if (last_byte) begin
        res.status    = ST_TRUNC;
        nxt.remaining = '0;
        nxt.acc       = '0;
      end else begin
        nxt.acc       = AccW'(byte_value[6:0] & lead_mask);
        nxt.remaining = lead_cnt - 3'd1;
      end
    end else if (byte_value[7:6] != ContTag) begin
      res.status    = ST_BADCONT;
      nxt.halted    = 1'b1;
      nxt.remaining = '0;
      nxt.acc       = '0;
    end else if (cont_rem == '0) begin
      fin_en  = 1'b1;
      fin_val = cont_acc;
    end else if (last_byte) begin
      res.status    = ST_TRUNC;
      nxt.remaining = '0;
      nxt.acc       = '0;
    end else begin
      nxt.acc       = cont_acc;
      nxt.remaining = cont_rem;
    end

    // Finish a character: replace values beyond 16 bits, halt on NUL
    if (fin_en) begin
      res.status    = ST_EMIT;
      res.code_unit = (fin_val[AccW-1:UnitW] != '0) ? ReplaceChar : fin_val[UnitW-1:0];
      nxt.remaining = '0;
      nxt.acc       = '0;
      if (fin_val == '0) nxt.halted = 1'b1;
    end

    // End of buffer clears all state
    if (last_byte) nxt = '0;
    res.halted_after = nxt.halted;
  end

endmodule

// ===== hdl/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder top level: input register, decode step, result register.
// Depends on u2u_pkg and u2u_step.
// Path: a byte moves from the input register through the decode step to the result
// register when that register is free; a held result keeps the byte waiting.
// Throughput: one byte per cycle unless unit_stall holds the result; the decode
// state updates as a byte moves from the input register to the result register.
// Reset (rst, synchronous): empties both registers and clears decode state.
module utf8_to_utf16_decoder
  import u2u_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic [ByteW-1:0] byte_value,
  input  logic             last_byte,
  output logic             unit_valid,
  input  logic             unit_stall,
  output logic [StatusW-1:0] status,
  output logic [UnitW-1:0] code_unit,
  output logic             halted_after
);

  logic             in_full;
  logic [ByteW-1:0] in_byte;
  logic             in_last;
  dec_state_t       state;
  dec_state_t       state_next;
  dec_result_t      step_res;
  dec_result_t      out_res;
  logic             advance;

  // Move a byte into the result register when that register is free
  assign advance    = in_full && (!unit_valid || !unit_stall);
  assign byte_stall = in_full && !advance;

  u2u_step u_step (
    .cur        (state),
    .byte_value (in_byte),
    .last_byte  (in_last),
    .nxt        (state_next),
    .res        (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= byte_value;
      in_last <= last_byte;
    end
  end

  // Decode state, updated once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else if (advance) begin
      unit_valid <= 1'b1;
    end else if (!unit_stall) begin
      unit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= step_res;
  end

  assign status       = out_res.status;
  assign code_unit    = out_res.code_unit;
  assign halted_after = out_res.halted_after;

  // Only emitted results carry a code unit
  a_unit_zero: assert property (@(posedge clk) disable iff (rst)
    unit_valid && (status != ST_EMIT) |-> code_unit == '0)
    else $error("code unit nonzero on non-emit result");

  // A last byte leaves the decoder in its reset state
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> state == '0)
    else $error("state not cleared after last byte");

  // A halted stream never has a sequence open
  a_halt_no_seq: assert property (@(posedge clk) disable iff (rst)
    state.halted |-> state.remaining == '0)
    else $error("open sequence while halted");

  // Input stalls only when both registers are held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> in_full && unit_valid && unit_stall)
    else $error("input stalled with room available");

endmodule

// ===== tb/utf8_to_utf16_decoder_tb.sv =====
// Self-checking testbench for utf8_to_utf16_decoder: byte streams in, one result per byte out.
// Depends on u2u_pkg and the decoder RTL; a scoreboard class predicts each result in order.
module utf8_to_utf16_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u2u_pkg::*;

  localparam int unsigned RandomBytes = 750;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 10;

  // Decoder prediction and in-order result check
  class u2u_scoreboard;
    logic [RemW-1:0] remaining;
    logic [AccW-1:0] acc;
    logic            halted;
    dec_result_t     expected_units[$];
    int unsigned     mismatches;

    function new();
      remaining  = '0;
      acc        = '0;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned count_lead_ones(logic [ByteW-1:0] b);
      int unsigned n;
      n = 0;
      while (n < 7 && b[7-n]) n++;
      return n;
    endfunction

    // Close a character: replace values beyond the BMP, halt on NUL
    function logic [UnitW-1:0] finish_char(logic [AccW-1:0] v);
      if (v[AccW-1:UnitW] != '0) v = AccW'(ReplaceChar);
      remaining = '0;
      acc       = '0;
      if (v == '0) halted = 1'b1;
      return v[UnitW-1:0];
    endfunction

    function void note_byte(logic [ByteW-1:0] b, logic last);
      dec_result_t res;
      int unsigned ones;
      res.status    = ST_PENDING;
      res.code_unit = '0;
      if (halted) begin
        res.status = ST_IGNORED;
      end else if (remaining == '0) begin
        ones = count_lead_ones(b);
        if (ones == 0) begin
          res.code_unit = finish_char(AccW'(b));
          res.status    = ST_EMIT;
        end else if (ones == 1 || ones > 6) begin
          res.status = ST_ILLEGAL;
        end else if (last) begin
          res.status = ST_TRUNC;
        end else begin
          acc       = AccW'(b & (8'hFF >> (ones + 1)));
          remaining = RemW'(ones - 1);
        end
      end else if (b[7:6] != ContTag) begin
        res.status = ST_BADCONT;
        halted     = 1'b1;
        remaining  = '0;
        acc        = '0;
      end else begin
        acc       = {acc[AccW-7:0], b[5:0]};
        remaining = remaining - 1'b1;
        if (remaining == '0) begin
          res.code_unit = finish_char(acc);
          res.status    = ST_EMIT;
        end else if (last) begin
          res.status = ST_TRUNC;
          remaining  = '0;
          acc        = '0;
        end
      end
      // End of buffer clears everything
      if (last) begin
        remaining = '0;
        acc       = '0;
        halted    = 1'b0;
      end
      res.halted_after = halted;
      expected_units.push_back(res);
    endfunction

    function void check_unit(logic [StatusW-1:0] st, logic [UnitW-1:0] unit, logic halt);
      dec_result_t want;
      if (expected_units.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: status=%0d unit=%h halted=%b", st, unit, halt);
        return;
      end
      want = expected_units.pop_front();
      if (st !== want.status || unit !== want.code_unit || halt !== want.halted_after) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("mismatch: status %0d/%0d unit %h/%h halted %b/%b (expected/actual)",
                   want.status, st, want.code_unit, unit, want.halted_after, halt);
      end
    endfunction

    function int unsigned pending();
      return expected_units.size();
    endfunction
  endclass

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             last;
  } byte_item_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               byte_valid   = 1'b0;
  logic               byte_stall;
  logic [ByteW-1:0]   byte_value   = '0;
  logic               last_byte    = 1'b0;
  logic               unit_valid;
  logic               unit_stall   = 1'b0;
  logic [StatusW-1:0] status;
  logic [UnitW-1:0]   code_unit;
  logic               halted_after;

  byte_item_t    stream_q[$];
  u2u_scoreboard sb;
  int unsigned   idle_cycles = 0;
  int unsigned   stall_mode  = 0;
  int unsigned   mode_left   = 0;
  int unsigned   stall_phase = 0;
  int unsigned   stall_period = 2;

  utf8_to_utf16_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_value   (byte_value),
    .last_byte    (last_byte),
    .unit_valid   (unit_valid),
    .unit_stall   (unit_stall),
    .status       (status),
    .code_unit    (code_unit),
    .halted_after (halted_after)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic add_byte(input logic [ByteW-1:0] v, input logic last);
    byte_item_t item;
    item.value = v;
    item.last  = last;
    stream_q.push_back(item);
  endtask

  function automatic logic [ByteW-1:0] lead_of(int unsigned n);
    return ~(8'hFF >> n) | (8'($urandom) & (8'hFF >> (n + 1)));
  endfunction

  function automatic logic [ByteW-1:0] cont_byte();
    return 8'h80 | (8'($urandom) & 8'h3F);
  endfunction

  function automatic int unsigned char_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 1;
    if (pick < 65) return 2;
    if (pick < 82) return 3;
    if (pick < 92) return 4;
    if (pick < 96) return 5;
    return 6;
  endfunction

  // Well-formed character of n bytes with random payload
  task automatic add_char(input int unsigned n);
    int unsigned k;
    if (n == 1) begin
      add_byte(8'($urandom_range(1, 127)), 1'b0);
    end else begin
      add_byte(lead_of(n), 1'b0);
      for (k = 1; k < n; k++) add_byte(cont_byte(), 1'b0);
    end
  endtask

  // Lead byte followed by too few continuation bytes
  task automatic add_broken_char();
    int unsigned n;
    int unsigned k;
    int unsigned conts;
    n     = $urandom_range(2, 6);
    conts = $urandom_range(0, n - 2);
    add_byte(lead_of(n), 1'b0);
    for (k = 0; k < conts; k++) add_byte(cont_byte(), 1'b0);
  endtask

  task automatic add_random_buffer();
    int unsigned nchars;
    int unsigned k;
    int unsigned pick;
    nchars = $urandom_range(1, 16);
    for (k = 0; k < nchars; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) add_char(char_length());
      else if (pick < 93) add_byte(8'($urandom_range(0, 255)), 1'b0);
      else if (pick == 93) add_byte(8'h00, 1'b0);
      else add_broken_char();
    end
    // Sometimes cut the last character off at the end of the buffer
    if ($urandom_range(0, 9) == 0) add_broken_char();
    stream_q[stream_q.size()-1].last = 1'b1;
  endtask

  task automatic build_directed();
    // ASCII max, lone continuation, illegal leads, two-byte character
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFE, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hFF, 1'b1);
    // Three-byte, four-byte beyond BMP, six-byte maximum, bad continuation, halted
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'hAC, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h9F, 1'b0);
    add_byte(8'h98, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFD, 1'b0);
    repeat (5) add_byte(8'hBF, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b1);
    // NUL halts until end of buffer
    add_byte(8'h00, 1'b0);
    add_byte(8'h41, 1'b1);
    // Truncated lead, truncated continuation, bad continuation on the last byte
    add_byte(8'hC3, 1'b1);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b1);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h41, 1'b1);
  endtask

  // Present bytes in bursts with random gaps; hold while stalled
  task automatic send_bytes();
    int unsigned idx;
    int unsigned burst_left;
    int unsigned gap_left;
    idx        = 0;
    burst_left = $urandom_range(1, 40);
    gap_left   = 0;
    while (idx < stream_q.size()) begin
      @(posedge clk);
      if (byte_valid && !byte_stall) idx++;
      if (byte_valid && byte_stall) continue;
      if (gap_left > 0) begin
        gap_left--;
        byte_valid <= 1'b0;
      end else if (idx < stream_q.size()) begin
        byte_valid <= 1'b1;
        byte_value <= stream_q[idx].value;
        last_byte  <= stream_q[idx].last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        byte_valid <= 1'b0;
      end
    end
  endtask

  // Receiver stall pattern: free-running, random, periodic or heavy
  always @(posedge clk) begin
    if (rst) begin
      unit_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode   = $urandom_range(0, 3);
        mode_left    = $urandom_range(20, 200);
        stall_period = $urandom_range(2, 5);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
        0: unit_stall <= 1'b0;
        1: unit_stall <= ($urandom_range(0, 2) == 0);
        2: unit_stall <= (stall_phase % stall_period != 0);
        default: unit_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Track transfers on both sides and watch for a stuck run
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) sb.note_byte(byte_value, last_byte);
      if (unit_valid && !unit_stall) sb.check_unit(status, code_unit, halted_after);
      if ((byte_valid && !byte_stall) || (unit_valid && !unit_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    sb = new();
    build_directed();
    while (stream_q.size() < RandomBytes + 25) add_random_buffer();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_bytes();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== utf8_to_utf16_decoder.f =====
hdl/u2u_pkg.sv
hdl/u2u_step.sv
hdl/utf8_to_utf16_decoder.sv
tb/utf8_to_utf16_decoder_tb.sv
